>>> rtl/fcsg_pkg.sv
// fcsg_pkg: field widths, microcode word layout, sequencer addresses and the
// microcode program of the filled circle span generator
// no dependencies
`default_nettype none

package fcsg_pkg;

  localparam int COORD_W   = 13;
  localparam int DIAM_W    = 6;
  localparam int SPAN_W    = 14;
  localparam int CLIP_W    = 12;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W    = 6;
  localparam int DEC_W     = 10;
  localparam int PC_W      = 3;

  localparam logic [DIAM_W-1:0] MAX_DIAMETER = 6'd61;

  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM = 2'd3;

  localparam logic [CLIP_W-1:0] CLIP_LEFT_RST   = 12'd0;
  localparam logic [CLIP_W-1:0] CLIP_TOP_RST    = 12'd0;
  localparam logic [CLIP_W-1:0] CLIP_RIGHT_RST  = 12'd1023;
  localparam logic [CLIP_W-1:0] CLIP_BOTTOM_RST = 12'd767;

  // program addresses
  localparam logic [PC_W-1:0] PC_IDLE = 3'd0;
  localparam logic [PC_W-1:0] PC_A0   = 3'd1;
  localparam logic [PC_W-1:0] PC_A1   = 3'd2;
  localparam logic [PC_W-1:0] PC_B0   = 3'd3;
  localparam logic [PC_W-1:0] PC_B1   = 3'd4;
  localparam logic [PC_W-1:0] PC_C0   = 3'd5;
  localparam logic [PC_W-1:0] PC_C1   = 3'd6;
  localparam logic [PC_W-1:0] PC_REJ  = 3'd7;

  // row offset: center row minus/plus x or y
  typedef enum logic [1:0] {ROW_MX, ROW_PX, ROW_MY, ROW_PY} row_t;
  // half width of the span
  typedef enum logic {SPAN_X, SPAN_Y} span_t;
  // how the last flag is formed
  typedef enum logic [1:0] {LAST_NO, LAST_YES, LAST_A, LAST_B} last_t;
  // branch kind
  typedef enum logic [1:0] {BR_NEXT, BR_LOAD, BR_PSIGN, BR_LOOPB} br_t;

  typedef struct packed {
    logic            emit;
    logic            empty;
    row_t            row;
    span_t           span;
    last_t           last;
    br_t             br;
    logic [PC_W-1:0] tgt;
  } ucode_t;

  typedef struct packed {
    logic  load;
    logic  step_a;
    logic  step_b;
    row_t  row;
    span_t span;
    logic  empty;
  } ctrl_t;

  typedef struct packed {
    logic reject;
    logic r_zero;
    logic p_neg;
    logic a_lt;
    logic a_eq;
    logic b_lt;
    logic b_eq;
  } stat_t;

  function automatic ucode_t fcsg_ucode(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{emit: 1'b0, empty: 1'b0, row: ROW_MX, span: SPAN_X, last: LAST_NO,
          br: BR_LOAD, tgt: PC_IDLE};
    case (pc)
      PC_IDLE: begin
        w.br = BR_LOAD;
      end
      PC_A0: begin
        w.emit = 1'b1; w.row = ROW_MX; w.span = SPAN_Y;
        w.br = BR_NEXT; w.tgt = PC_A1;
      end
      PC_A1: begin
        w.emit = 1'b1; w.row = ROW_PX; w.span = SPAN_Y; w.last = LAST_A;
        w.br = BR_PSIGN;
      end
      PC_B0: begin
        w.emit = 1'b1; w.row = ROW_MY; w.span = SPAN_X;
        w.br = BR_NEXT; w.tgt = PC_B1;
      end
      PC_B1: begin
        w.emit = 1'b1; w.row = ROW_PY; w.span = SPAN_X; w.last = LAST_B;
        w.br = BR_LOOPB;
      end
      PC_C0: begin
        w.emit = 1'b1; w.row = ROW_MY; w.span = SPAN_X;
        w.br = BR_NEXT; w.tgt = PC_C1;
      end
      PC_C1: begin
        w.emit = 1'b1; w.row = ROW_PY; w.span = SPAN_X; w.last = LAST_YES;
        w.br = BR_NEXT; w.tgt = PC_IDLE;
      end
      PC_REJ: begin
        w.emit = 1'b1; w.empty = 1'b1; w.last = LAST_YES;
        w.br = BR_NEXT; w.tgt = PC_IDLE;
      end
      default: begin
        w.br = BR_LOAD;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> rtl/fcsg_channels.sv
// fcsg_cmd_if and fcsg_span_if: valid/ready channels for circle commands
// and span results; depends on fcsg_pkg
`default_nettype none

interface fcsg_cmd_if;
  import fcsg_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic        [DIAM_W-1:0]  diameter;

  modport source (output valid, center_x, center_y, diameter, input ready);
  modport sink   (input valid, center_x, center_y, diameter, output ready);
endinterface

interface fcsg_span_if;
  import fcsg_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [SPAN_W-1:0] span_row;
  logic signed [SPAN_W-1:0] span_left;
  logic signed [SPAN_W-1:0] span_right;
  logic                     empty_res;
  logic                     last;

  modport source (output valid, span_row, span_left, span_right, empty_res, last,
                  input ready);
  modport sink   (input valid, span_row, span_left, span_right, empty_res, last,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/fcsg_datapath.sv
// fcsg_datapath: clip registers, midpoint recurrence registers and span
// arithmetic driven by the sequencer's control word; depends on fcsg_pkg
`default_nettype none

module fcsg_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [fcsg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fcsg_pkg::CLIP_W-1:0]       cfg_data,
  input  wire logic signed [fcsg_pkg::COORD_W-1:0] center_x,
  input  wire logic signed [fcsg_pkg::COORD_W-1:0] center_y,
  input  wire logic [fcsg_pkg::DIAM_W-1:0]       diameter,
  input  wire fcsg_pkg::ctrl_t                   ctrl,
  output fcsg_pkg::stat_t                        stat,
  output logic signed [fcsg_pkg::SPAN_W-1:0]     span_row,
  output logic signed [fcsg_pkg::SPAN_W-1:0]     span_left,
  output logic signed [fcsg_pkg::SPAN_W-1:0]     span_right
);
  import fcsg_pkg::*;

  logic [CLIP_W-1:0] win_left, win_top, win_right, win_bottom;

  logic        [STEP_W-1:0]  step_x, step_y;
  logic signed [DEC_W-1:0]   decision;
  logic signed [COORD_W-1:0] held_center_x, held_center_y;

  logic        [DIAM_W-1:0]  d_sat;
  logic        [STEP_W-1:0]  radius;
  logic signed [SPAN_W-1:0]  cx14, cy14, r14;
  logic signed [DEC_W-1:0]   inc_a, inc_b;
  logic signed [STEP_W:0]    dxy;
  logic        [STEP_W-1:0]  x_inc, y_dec;
  logic signed [SPAN_W-1:0]  hcx14, hcy14, row_off, half_w;
  logic        [STEP_W-1:0]  row_v, span_v;

  // command decode
  always_comb begin
    d_sat  = (diameter > MAX_DIAMETER) ? MAX_DIAMETER : diameter;
    radius = STEP_W'(d_sat >> 1);
    cx14   = SPAN_W'(center_x);
    cy14   = SPAN_W'(center_y);
    r14    = signed'({{(SPAN_W-STEP_W){1'b0}}, radius});
  end

  // bounding box against clip window (signed compares), recurrence
  // increments and loop tests
  always_comb begin
    stat.reject = (cx14 + r14 < signed'({2'b00, win_left}))  ||
                  (cx14 - r14 > signed'({2'b00, win_right})) ||
                  (cy14 + r14 < signed'({2'b00, win_top}))   ||
                  (cy14 - r14 > signed'({2'b00, win_bottom}));
    stat.r_zero = (radius == '0);
    x_inc  = step_x + STEP_W'(1);
    y_dec  = step_y - STEP_W'(1);
    inc_a  = signed'({{(DEC_W-STEP_W-2){1'b0}}, step_x, 2'b00}) + DEC_W'(6);
    dxy    = signed'({1'b0, step_x}) - signed'({1'b0, step_y});
    inc_b  = signed'({{(DEC_W-STEP_W-3){dxy[STEP_W]}}, dxy, 2'b00}) + DEC_W'(10);
    stat.p_neg = decision[DEC_W-1];
    stat.a_lt  = x_inc < step_y;
    stat.a_eq  = x_inc == step_y;
    stat.b_lt  = x_inc < y_dec;
    stat.b_eq  = x_inc == y_dec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_left   <= CLIP_LEFT_RST;
      win_top    <= CLIP_TOP_RST;
      win_right  <= CLIP_RIGHT_RST;
      win_bottom <= CLIP_BOTTOM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLIP_LEFT:   win_left   <= cfg_data;
        REG_CLIP_TOP:    win_top    <= cfg_data;
        REG_CLIP_RIGHT:  win_right  <= cfg_data;
        REG_CLIP_BOTTOM: win_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_center_x <= '0;
      held_center_y <= '0;
      step_x        <= '0;
      step_y        <= '0;
      decision      <= '0;
    end else if (ctrl.load) begin
      held_center_x <= center_x;
      held_center_y <= center_y;
      step_x        <= '0;
      step_y        <= radius;
      decision      <= DEC_W'(3) - signed'({{(DEC_W-DIAM_W){1'b0}}, d_sat});
    end else if (ctrl.step_a) begin
      decision <= decision + inc_a;
      step_x   <= x_inc;
    end else if (ctrl.step_b) begin
      decision <= decision + inc_b;
      step_x   <= x_inc;
      step_y   <= y_dec;
    end
  end

  // span payload from held center and current x, y
  always_comb begin
    hcx14   = SPAN_W'(held_center_x);
    hcy14   = SPAN_W'(held_center_y);
    row_v   = (ctrl.row == ROW_MX || ctrl.row == ROW_PX) ? step_x : step_y;
    span_v  = (ctrl.span == SPAN_Y) ? step_y : step_x;
    row_off = signed'({{(SPAN_W-STEP_W){1'b0}}, row_v});
    half_w  = signed'({{(SPAN_W-STEP_W){1'b0}}, span_v});
    if (ctrl.empty) begin
      span_row   = '0;
      span_left  = '0;
      span_right = '0;
    end else begin
      span_row   = (ctrl.row == ROW_MX || ctrl.row == ROW_MY) ? hcy14 - row_off
                                                              : hcy14 + row_off;
      span_left  = hcx14 - half_w;
      span_right = hcx14 + half_w;
    end
  end

endmodule

`default_nettype wire

>>> rtl/fcsg_sequencer.sv
// fcsg_sequencer: step counter over the microcode program, branch logic and
// handshake control; depends on fcsg_pkg
`default_nettype none

module fcsg_sequencer (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 out_last,
  input  wire fcsg_pkg::stat_t stat,
  output fcsg_pkg::ctrl_t      ctrl
);
  import fcsg_pkg::*;

  logic [PC_W-1:0] pc, pc_next;
  ucode_t          word;
  logic            fire;

  always_comb begin
    word      = fcsg_ucode(pc);
    in_ready  = (word.br == BR_LOAD);
    out_valid = word.emit;
    fire      = word.emit ? out_ready : in_valid;
  end

  always_comb begin
    case (word.last)
      LAST_NO:  out_last = 1'b0;
      LAST_YES: out_last = 1'b1;
      LAST_A:   out_last = stat.p_neg && !stat.a_lt && !stat.a_eq;
      LAST_B:   out_last = !stat.b_lt && !stat.b_eq;
      default:  out_last = 1'b0;
    endcase
  end

  always_comb begin
    ctrl.load   = fire && (word.br == BR_LOAD);
    ctrl.step_a = fire && (word.br == BR_PSIGN) && stat.p_neg;
    ctrl.step_b = fire && (word.br == BR_LOOPB);
    ctrl.row    = word.row;
    ctrl.span   = word.span;
    ctrl.empty  = word.empty;
  end

  always_comb begin
    pc_next = pc;
    if (fire) begin
      case (word.br)
        BR_NEXT:  pc_next = word.tgt;
        BR_LOAD:  pc_next = stat.reject ? PC_REJ : (stat.r_zero ? PC_C0 : PC_A0);
        BR_PSIGN: begin
          if (!stat.p_neg) pc_next = PC_B0;
          else if (stat.a_lt) pc_next = PC_A0;
          else if (stat.a_eq) pc_next = PC_C0;
          else pc_next = PC_IDLE;
        end
        BR_LOOPB: begin
          if (stat.b_lt) pc_next = PC_A0;
          else if (stat.b_eq) pc_next = PC_C0;
          else pc_next = PC_IDLE;
        end
        default:  pc_next = PC_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("command and span offered in the same cycle");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_last) |=> (pc == PC_IDLE))
    else $error("sequencer not idle after last transfer");

  a_reject_path: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && stat.reject) |=> (pc == PC_REJ))
    else $error("rejected command did not go to empty result");

endmodule

`default_nettype wire

>>> rtl/filled_circle_span_generator_unit.sv
// filled_circle_span_generator_unit: top level of the filled circle span
// generator; depends on fcsg_pkg, fcsg_channels, fcsg_sequencer, fcsg_datapath
`default_nettype none

// once a command transfers, its first span is offered the next cycle
// one span per cycle while the sink takes them; the next command is taken
// after all N results (N up to 62 at diameter 61, one for a rejected circle)
// the rate is set by the microcode program, which runs one emitting step per span
// synchronous reset: clip window to 0, 0, 1023, 767, walk registers to zero
// and the sequencer to idle
module filled_circle_span_generator_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [fcsg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fcsg_pkg::CLIP_W-1:0]    cfg_data,
  fcsg_cmd_if.sink                            cmd,
  fcsg_span_if.source                         span
);
  import fcsg_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // microcoded control: program step per span, branches on recurrence flags
  fcsg_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (span.valid),
    .out_ready (span.ready),
    .out_last  (span.last),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // clip registers, x/y/decision registers and span arithmetic
  fcsg_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .center_x   (cmd.center_x),
    .center_y   (cmd.center_y),
    .diameter   (cmd.diameter),
    .ctrl       (ctrl),
    .stat       (stat),
    .span_row   (span.span_row),
    .span_left  (span.span_left),
    .span_right (span.span_right)
  );

  // empty marker comes straight from the control word
  assign span.empty_res = ctrl.empty;

endmodule

`default_nettype wire

>>> verif/filled_circle_span_generator_unit_tb.sv
// filled_circle_span_generator_unit_tb: self-checking bench for the filled circle span
// generator; sends circle commands and clip window writes, predicts and checks every span
// depends on fcsg_pkg, fcsg_channels and filled_circle_span_generator_unit

module filled_circle_span_generator_unit_tb;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 6;
  localparam int RESULT_LIMIT = 64;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 160;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int MAX_REPORTS  = 10;

  // one span as seen on the result channel
  typedef struct packed {
    logic signed [fcsg_pkg::SPAN_W-1:0] row;
    logic signed [fcsg_pkg::SPAN_W-1:0] left;
    logic signed [fcsg_pkg::SPAN_W-1:0] right;
    logic                               empty;
    logic                               last;
  } span_rec_t;

  // where the last command left the span walk
  typedef enum logic [1:0] {PH_STEP, PH_STEP_DOWN, PH_CLOSE, PH_REJECT} circle_phase_t;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_we;
  logic [fcsg_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [fcsg_pkg::CLIP_W-1:0]    cfg_data;

  fcsg_cmd_if  cmd_if ();
  fcsg_span_if span_if ();

  filled_circle_span_generator_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_if),
    .span      (span_if)
  );

  always #CLK_HALF clk = ~clk;

  // bench copy of the clip window and of the walk state
  logic [fcsg_pkg::CLIP_W-1:0]          win_left;
  logic [fcsg_pkg::CLIP_W-1:0]          win_top;
  logic [fcsg_pkg::CLIP_W-1:0]          win_right;
  logic [fcsg_pkg::CLIP_W-1:0]          win_bottom;
  logic [fcsg_pkg::STEP_W-1:0]          walk_x;
  logic [fcsg_pkg::STEP_W-1:0]          walk_y;
  int                                   walk_decision;
  logic signed [fcsg_pkg::COORD_W-1:0]  held_cx;
  logic signed [fcsg_pkg::COORD_W-1:0]  held_cy;
  circle_phase_t                        walk_phase;

  span_rec_t circle_batch[$];   // spans of the command being predicted
  span_rec_t pending_spans[$];  // spans predicted but not yet transferred

  bit idle_on        = 1'b1;    // random gaps on both channels
  bit hold_spans_req = 1'b0;    // ask the result side for one long hold-off

  int mismatch_count   = 0;
  int spans_checked    = 0;
  int circles_sent     = 0;
  int circles_rejected = 0;
  int clip_writes      = 0;
  int cycle_count      = 0;

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 7) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  // most diameters small so the run stays short, a few at the top end
  // (62 and 63 exercise the saturation)
  function automatic logic [fcsg_pkg::DIAM_W-1:0] rand_diameter();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return fcsg_pkg::DIAM_W'($urandom_range(0, 15));
    if (sel < 9) return fcsg_pkg::DIAM_W'($urandom_range(16, 47));
    return fcsg_pkg::DIAM_W'($urandom_range(48, 63));
  endfunction

  // a coordinate in or near the window lo..hi, or anywhere in the 13-bit range
  function automatic logic signed [fcsg_pkg::COORD_W-1:0] rand_coord(
    input logic [fcsg_pkg::CLIP_W-1:0] lo,
    input logic [fcsg_pkg::CLIP_W-1:0] hi
  );
    int width;
    int v;
    if ($urandom_range(0, 4) == 0) return fcsg_pkg::COORD_W'($urandom());
    width = (int'(hi) > int'(lo)) ? int'(hi) - int'(lo) : 0;
    v = int'(lo) - 40 + $urandom_range(0, width + 80);
    if (v > 4095) v = 4095;
    return v[fcsg_pkg::COORD_W-1:0];
  endfunction

  // append one span to the batch unless the result cap is reached
  function automatic void add_span(input int row, input int left, input int right);
    span_rec_t s;
    if (circle_batch.size() >= RESULT_LIMIT) return;
    s.row   = row[fcsg_pkg::SPAN_W-1:0];
    s.left  = left[fcsg_pkg::SPAN_W-1:0];
    s.right = right[fcsg_pkg::SPAN_W-1:0];
    s.empty = 1'b0;
    s.last  = 1'b0;
    circle_batch.push_back(s);
  endfunction

  // midpoint walk for one accepted command; appends its spans to pending_spans
  function automatic void predict_circle_spans(
    input logic signed [fcsg_pkg::COORD_W-1:0] cx_in,
    input logic signed [fcsg_pkg::COORD_W-1:0] cy_in,
    input logic        [fcsg_pkg::DIAM_W-1:0]  d_in
  );
    int cx, cy, d, r, p, x, y;
    span_rec_t s;
    cx = cx_in;
    cy = cy_in;
    d  = d_in;
    if (d > int'(fcsg_pkg::MAX_DIAMETER)) d = int'(fcsg_pkg::MAX_DIAMETER);
    r = d / 2;
    p = 3 - d;
    x = 0;
    y = r;
    held_cx = cx_in;
    held_cy = cy_in;

    // bounding box entirely outside the window: a single empty result
    if (cx + r < int'(win_left) || cx - r > int'(win_right) ||
        cy + r < int'(win_top) || cy - r > int'(win_bottom)) begin
      s = '0;
      s.empty = 1'b1;
      s.last  = 1'b1;
      pending_spans.push_back(s);
      walk_x        = x[fcsg_pkg::STEP_W-1:0];
      walk_y        = y[fcsg_pkg::STEP_W-1:0];
      walk_decision = p;
      walk_phase    = PH_REJECT;
      circles_rejected++;
      return;
    end

    circle_batch.delete();
    while (x < y && circle_batch.size() < RESULT_LIMIT) begin
      add_span(cy - x, cx - y, cx + y);
      add_span(cy + x, cx - y, cx + y);
      walk_phase = PH_STEP;
      if (p < 0) begin
        p = p + 4 * x + 6;
      end else begin
        add_span(cy - y, cx - x, cx + x);
        add_span(cy + y, cx - x, cx + x);
        walk_phase = PH_STEP_DOWN;
        p = p + 4 * (x - y) + 10;
        y--;
      end
      x++;
    end
    // closing pair when the walk meets the diagonal
    if (x == y && circle_batch.size() < RESULT_LIMIT) begin
      add_span(cy - y, cx - x, cx + x);
      add_span(cy + y, cx - x, cx + x);
      walk_phase = PH_CLOSE;
    end
    walk_x        = x[fcsg_pkg::STEP_W-1:0];
    walk_y        = y[fcsg_pkg::STEP_W-1:0];
    walk_decision = p;

    s = circle_batch.pop_back();
    s.last = 1'b1;
    circle_batch.push_back(s);
    while (circle_batch.size() != 0) pending_spans.push_back(circle_batch.pop_front());
  endfunction

  // offer one command, with an optional gap first, and wait for its transfer
  task automatic send_circle(
    input logic signed [fcsg_pkg::COORD_W-1:0] cx,
    input logic signed [fcsg_pkg::COORD_W-1:0] cy,
    input logic        [fcsg_pkg::DIAM_W-1:0]  d
  );
    int gap;
    gap = (idle_on && $urandom_range(0, 1) == 1) ? gap_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      cmd_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd_if.valid    <= 1'b1;
    cmd_if.center_x <= cx;
    cmd_if.center_y <= cy;
    cmd_if.diameter <= d;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    predict_circle_spans(cx, cy, d);
    circles_sent++;
  endtask

  // stop offering, wait for every predicted span, then let the block settle
  task automatic drain_spans();
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_clip(
    input logic [fcsg_pkg::CFG_IDX_W-1:0] idx,
    input logic [fcsg_pkg::CLIP_W-1:0]    val
  );
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      fcsg_pkg::REG_CLIP_LEFT:   win_left   = val;
      fcsg_pkg::REG_CLIP_TOP:    win_top    = val;
      fcsg_pkg::REG_CLIP_RIGHT:  win_right  = val;
      fcsg_pkg::REG_CLIP_BOTTOM: win_bottom = val;
      default: ;
    endcase
    clip_writes++;
  endtask

  // whole window at once, only once the block has gone idle
  task automatic set_clip_window(
    input logic [fcsg_pkg::CLIP_W-1:0] l,
    input logic [fcsg_pkg::CLIP_W-1:0] t,
    input logic [fcsg_pkg::CLIP_W-1:0] r,
    input logic [fcsg_pkg::CLIP_W-1:0] b
  );
    drain_spans();
    write_clip(fcsg_pkg::REG_CLIP_LEFT, l);
    write_clip(fcsg_pkg::REG_CLIP_TOP, t);
    write_clip(fcsg_pkg::REG_CLIP_RIGHT, r);
    write_clip(fcsg_pkg::REG_CLIP_BOTTOM, b);
  endtask

  // diameter and coordinate extremes plus exact reject boundaries, reset window
  task automatic test_corner_circles();
    send_circle(100, 100, 0);        // zero diameter: closing pair only
    send_circle(100, 100, 1);        // one: radius still zero
    send_circle(100, 100, 2);
    send_circle(100, 100, 3);
    send_circle(500, 400, 61);       // largest legal diameter
    send_circle(500, 400, 62);       // oversized, saturates
    send_circle(500, 400, 63);
    send_circle(-4096, -4096, 63);   // most negative center, rejected
    send_circle(4095, 4095, 63);     // most positive center, rejected
    send_circle(-30, 300, 61);       // touches the left edge
    send_circle(-31, 300, 61);       // one pixel past it
    send_circle(1053, 300, 61);      // touches the right edge
    send_circle(1054, 300, 61);
    send_circle(300, -30, 61);       // top edge
    send_circle(300, -31, 61);
    send_circle(300, 797, 61);       // bottom edge
    send_circle(300, 798, 61);
    send_circle(0, 0, 10);
    send_circle(1023, 767, 20);
    send_circle(-1, -1, 4);
    send_circle(5, 5, 61);           // spans reach negative columns
    send_circle(4095, 0, 0);
  endtask

  // degenerate, full, corner and inverted windows, then back to the reset window
  task automatic test_clip_window_extremes();
    set_clip_window(12'd0, 12'd0, 12'd0, 12'd0);
    send_circle(0, 0, 0);
    send_circle(0, 0, 61);
    send_circle(1, 0, 0);
    send_circle(-1, 0, 2);
    send_circle(30, -30, 61);
    set_clip_window(12'd4095, 12'd4095, 12'd4095, 12'd4095);
    send_circle(4095, 4095, 0);
    send_circle(4094, 4095, 0);
    send_circle(4095, 4095, 61);
    send_circle(4065, 4065, 61);
    set_clip_window(12'd0, 12'd0, 12'd4095, 12'd4095);
    send_circle(-4096, -4096, 61);
    send_circle(4095, -1, 61);
    send_circle(2048, 2048, 33);
    // left past right and top past bottom: compares still apply as written
    set_clip_window(12'd3000, 12'd2000, 12'd100, 12'd50);
    send_circle(100, 100, 61);
    send_circle(3000, 2000, 61);
    send_circle(1500, 1000, 61);
    set_clip_window(fcsg_pkg::CLIP_LEFT_RST, fcsg_pkg::CLIP_TOP_RST,
                    fcsg_pkg::CLIP_RIGHT_RST, fcsg_pkg::CLIP_BOTTOM_RST);
  endtask

  // phases of random commands, each after the first under a fresh window, each with its own idling mode
  task automatic test_random_circles();
    int phase;
    int k;
    logic [fcsg_pkg::CLIP_W-1:0] l, t;
    for (phase = 0; phase < 7; phase++) begin
      if (phase > 0) begin
        if ($urandom_range(0, 5) == 0) begin
          // anything goes, often inverted
          set_clip_window(fcsg_pkg::CLIP_W'($urandom()), fcsg_pkg::CLIP_W'($urandom()),
                          fcsg_pkg::CLIP_W'($urandom()), fcsg_pkg::CLIP_W'($urandom()));
        end else begin
          l = fcsg_pkg::CLIP_W'($urandom_range(0, 3000));
          t = fcsg_pkg::CLIP_W'($urandom_range(0, 3000));
          set_clip_window(l, t, fcsg_pkg::CLIP_W'(l + $urandom_range(0, 1095)),
                          fcsg_pkg::CLIP_W'(t + $urandom_range(0, 1095)));
        end
      end
      // one phase in four runs without any gaps
      idle_on = ($urandom_range(0, 3) != 0);
      for (k = 0; k < 20; k++) begin
        send_circle(rand_coord(win_left, win_right), rand_coord(win_top, win_bottom),
                    rand_diameter());
      end
    end
    idle_on = 1'b1;
  endtask

  // result side holds off while commands keep coming, so the input stalls
  task automatic test_output_backpressure();
    int k;
    drain_spans();
    idle_on        = 1'b0;
    hold_spans_req = 1'b1;
    for (k = 0; k < 16; k++) begin
      send_circle(rand_coord(win_left, win_right), rand_coord(win_top, win_bottom),
                  fcsg_pkg::DIAM_W'($urandom_range(16, 40)));
    end
    idle_on = 1'b1;
  endtask

  // the sender stops until every span is in, then resumes
  task automatic test_sender_pause();
    int k;
    for (k = 0; k < 16; k++) begin
      if (k == 8) drain_spans();
      send_circle(rand_coord(win_left, win_right), rand_coord(win_top, win_bottom),
                  rand_diameter());
    end
  endtask

  // result side: random stalls, or one long hold-off on request
  initial begin : span_sink
    int stall;
    span_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_spans_req) begin
        span_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_spans_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        span_if.ready <= 1'b0;
        stall = gap_len();
        repeat (stall) @(negedge clk);
      end
      span_if.ready <= 1'b1;
      @(negedge clk);
    end
  end

  // every span transfer against the oldest prediction
  always @(posedge clk) begin : span_check
    span_rec_t want;
    logic      bad;
    if (!rst && span_if.valid && span_if.ready) begin
      if (pending_spans.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("unexpected span at %0t: row %0d left %0d right %0d empty %0b last %0b",
                   $time, span_if.span_row, span_if.span_left, span_if.span_right,
                   span_if.empty_res, span_if.last);
        mismatch_count++;
      end else begin
        want = pending_spans.pop_front();
        bad  = (span_if.span_row   !== want.row)   ||
               (span_if.span_left  !== want.left)  ||
               (span_if.span_right !== want.right) ||
               (span_if.empty_res  !== want.empty) ||
               (span_if.last       !== want.last);
        if (bad) begin
          if (mismatch_count < MAX_REPORTS)
            $display({"span differs at %0t (expected/actual): row %0d/%0d left %0d/%0d ",
                      "right %0d/%0d empty %0b/%0b last %0b/%0b"}, $time,
                     $signed(want.row), span_if.span_row,
                     $signed(want.left), span_if.span_left,
                     $signed(want.right), span_if.span_right,
                     want.empty, span_if.empty_res, want.last, span_if.last);
          mismatch_count++;
        end
        spans_checked++;
      end
    end
  end

  // run limit, far above the slowest legal run
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d spans still outstanding",
             cycle_count, pending_spans.size());
    $display("filled_circle_span_generator_unit: mismatch");
    $finish;
  end

  initial begin : main_seq
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = fcsg_pkg::REG_CLIP_LEFT;
    cfg_data        = '0;
    cmd_if.valid    = 1'b0;
    cmd_if.center_x = '0;
    cmd_if.center_y = '0;
    cmd_if.diameter = '0;
    win_left        = fcsg_pkg::CLIP_LEFT_RST;
    win_top         = fcsg_pkg::CLIP_TOP_RST;
    win_right       = fcsg_pkg::CLIP_RIGHT_RST;
    win_bottom      = fcsg_pkg::CLIP_BOTTOM_RST;
    walk_x          = '0;
    walk_y          = '0;
    walk_decision   = 0;
    held_cx         = '0;
    held_cy         = '0;
    walk_phase      = PH_STEP;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    test_corner_circles();
    test_clip_window_extremes();
    test_random_circles();
    test_output_backpressure();
    test_sender_pause();
    drain_spans();

    $display("run covered %0d circle commands (%0d rejected by the window), %0d spans checked",
             circles_sent, circles_rejected, spans_checked);
    $display("with %0d clip writes incl. empty, full and inverted windows and a long output hold",
             clip_writes);
    if (mismatch_count == 0) begin
      $display("filled_circle_span_generator_unit: match");
    end else begin
      $display("%0d span mismatches", mismatch_count);
      $display("filled_circle_span_generator_unit: mismatch");
    end
    $finish;
  end

endmodule
